>>> hw/rtl/bfea_pkg.sv
// Shared types, widths and constants of the edge-averaged 3x3 box filter.
// Holds the reciprocal divide used on the neighborhood sum.
// No dependencies; every other RTL file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bfea_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned CFG_W        = 11;
  localparam int unsigned SUM_W        = 12;   // 9 * 255 fits in 12 bits
  localparam int unsigned CNT_W        = 4;    // neighbor count, at most 9
  localparam int unsigned MAX_SIZE_DEF = 1024;
  localparam int unsigned SIZE_RESET   = 1024; // image_size after reset
  localparam int unsigned PIX_MAX      = 255;

  // Neighbor counts that occur inside the image.
  localparam logic [CNT_W-1:0] CNT_INNER  = CNT_W'(9);
  localparam logic [CNT_W-1:0] CNT_EDGE   = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_CORNER = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_SINGLE = CNT_W'(1);

  // Reciprocals for truncating divides by 9 and 6, scaled by 2^RECIP_SHIFT.
  localparam int unsigned RECIP_SHIFT = 15;
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(3641);
  localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'(5462);
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  // Control for one item on its way into the window stage.
  typedef struct packed {
    logic       emit;    // item produces a result
    logic       last;    // result is the final pixel of the image
    logic [2:0] row_ok;  // window rows that lie inside the image
    logic [2:0] col_ok;  // window columns that lie inside the image
  } pos_info_t;

  // Truncated mean: sum / cnt for cnt in {1, 4, 6, 9}.
  function automatic logic [PIX_W-1:0] div_by_count(input logic [SUM_W-1:0] sum,
                                                    input logic [CNT_W-1:0] cnt);
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  quo;
    prod = '0;
    quo  = sum[PIX_W-1:0];
    unique case (cnt)
      CNT_INNER: begin
        prod = PROD_W'(sum) * PROD_W'(RECIP9);
        quo  = prod[RECIP_SHIFT +: PIX_W];
      end
      CNT_EDGE: begin
        prod = PROD_W'(sum) * PROD_W'(RECIP6);
        quo  = prod[RECIP_SHIFT +: PIX_W];
      end
      CNT_CORNER: begin
        quo = sum[2 +: PIX_W];
      end
      default: begin
        quo = sum[PIX_W-1:0];
      end
    endcase
    return quo;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bfea_pos_ctrl.sv
// Position tracking of the box filter: image side register, input and output
// raster counters, drain handling and per-item window masks.
// Depends on bfea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfea_pos_ctrl #(
  parameter int unsigned MAX_SIZE = bfea_pkg::MAX_SIZE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bfea_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                            acc_i,
  input  wire logic                            req_type_i,
  input  wire logic [bfea_pkg::PIX_W-1:0]      pixel_i,
  output logic                                 take_o,
  output logic [bfea_pkg::PIX_W-1:0]           px_o,
  output logic [$clog2(MAX_SIZE)-1:0]          col_o,
  output bfea_pkg::pos_info_t                  info_o
);
  import bfea_pkg::*;

  localparam int unsigned CntW    = $clog2(MAX_SIZE + 2);
  localparam int unsigned AddrW   = $clog2(MAX_SIZE);
  localparam int unsigned WideW   = (CFG_W > CntW) ? CFG_W : CntW;
  localparam int unsigned SideRst = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;

  logic [CntW-1:0]  side_q, side_d;
  logic [CntW-1:0]  in_row_q, in_row_d, in_col_q, in_col_d;
  logic [CntW-1:0]  out_row_q, out_row_d, out_col_q, out_col_d;
  logic [CntW-1:0]  side_m1, in_col_inc, out_col_inc;
  logic [WideW-1:0] cfg_ext;
  logic             in_image;

  assign side_m1     = side_q - CntW'(1);
  assign in_col_inc  = in_col_q + CntW'(1);
  assign out_col_inc = out_col_q + CntW'(1);
  assign cfg_ext     = WideW'(cfg_wdata_i);
  assign in_image    = in_row_q < side_q;

  // Drop drain ticks while the image is still arriving.
  assign take_o = acc_i && !(in_image && req_type_i);
  assign px_o   = in_image ? pixel_i : '0;
  assign col_o  = in_col_q[AddrW-1:0];

  always_comb begin
    info_o.emit   = (in_row_q >= CntW'(2)) ||
                    ((in_row_q == CntW'(1)) && (in_col_q != '0));
    info_o.last   = info_o.emit && (out_row_q == side_m1) && (out_col_q == side_m1);
    info_o.row_ok = {(out_row_q + CntW'(1)) < side_q, out_row_q < side_q,
                     out_row_q != '0};
    info_o.col_ok = {(out_col_q + CntW'(1)) < side_q, out_col_q < side_q,
                     out_col_q != '0};
  end

  always_comb begin
    side_d    = side_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (cfg_we_i) begin
      // Clamp the side and restart the frame.
      if (cfg_ext == '0) begin
        side_d = CntW'(1);
      end else if (cfg_ext > WideW'(MAX_SIZE)) begin
        side_d = CntW'(MAX_SIZE);
      end else begin
        side_d = CntW'(cfg_ext);
      end
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else if (take_o) begin
      if (in_col_inc >= side_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + CntW'(1);
      end else begin
        in_col_d = in_col_inc;
      end
      if (info_o.emit) begin
        if (out_col_inc >= side_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + CntW'(1);
        end else begin
          out_col_d = out_col_inc;
        end
      end
      if (info_o.last) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q    <= CntW'(SideRst);
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      side_q    <= side_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bfea_line_buf.sv
// Two-row line buffer of the box filter, one word per column holding the
// row above and the row two above. Registered read with write forwarding.
// Depends on bfea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfea_line_buf #(
  parameter int unsigned MAX_SIZE = bfea_pkg::MAX_SIZE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [$clog2(MAX_SIZE)-1:0]   rd_addr_i,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(MAX_SIZE)-1:0]   wr_addr_i,
  input  wire logic [bfea_pkg::PIX_W-1:0]    wr_above_i,
  input  wire logic [bfea_pkg::PIX_W-1:0]    wr_two_above_i,
  output logic [bfea_pkg::PIX_W-1:0]         above_o,
  output logic [bfea_pkg::PIX_W-1:0]         two_above_o
);
  import bfea_pkg::*;

  localparam int unsigned WordW = 2 * PIX_W;

  logic [WordW-1:0] mem [MAX_SIZE];
  logic [WordW-1:0] rd_q, fwd_data_q, wr_word, rd_word;
  logic             fwd_hit_q;

  assign wr_word = {wr_above_i, wr_two_above_i};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_word;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_word;
    end
  end

  // A write landing on the read address at the same edge wins over the array.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_word     = fwd_hit_q ? fwd_data_q : rd_q;
  assign above_o     = rd_word[PIX_W +: PIX_W];
  assign two_above_o = rd_word[0 +: PIX_W];

endmodule

`default_nettype wire

>>> hw/rtl/bfea_window.sv
// 3x3 window of the box filter: column shift and masked neighborhood sum
// with the matching neighbor count.
// Depends on bfea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfea_window (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clr_i,
  input  wire logic                        shift_i,
  input  wire logic [bfea_pkg::PIX_W-1:0]  top_i,
  input  wire logic [bfea_pkg::PIX_W-1:0]  mid_i,
  input  wire logic [bfea_pkg::PIX_W-1:0]  px_i,
  input  bfea_pkg::pos_info_t              info_i,
  output logic [bfea_pkg::SUM_W-1:0]       sum_o,
  output logic [bfea_pkg::CNT_W-1:0]       cnt_o
);
  import bfea_pkg::*;

  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];
  logic [1:0]       n_rows, n_cols;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3 + 1];
      win_d[r*3 + 1] = win_q[r*3 + 2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = px_i;
  end

  always_comb begin
    sum_o = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (info_i.row_ok[r] && info_i.col_ok[c]) begin
          sum_o = sum_o + SUM_W'(win_d[r*3 + c]);
        end
      end
    end
  end

  assign n_rows = 2'(info_i.row_ok[0]) + 2'(info_i.row_ok[1]) + 2'(info_i.row_ok[2]);
  assign n_cols = 2'(info_i.col_ok[0]) + 2'(info_i.col_ok[1]) + 2'(info_i.col_ok[2]);
  assign cnt_o  = CNT_W'(n_rows) * CNT_W'(n_cols);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (clr_i) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/box_filter_3x3_edge_average.sv
// Top level of the edge-averaged 3x3 box filter on a streamed square image.
// Depends on bfea_pkg, bfea_pos_ctrl, bfea_line_buf and bfea_window.
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_ready_o    req_type_i, pixel_i
//   out      out  out_valid_o / out_ready_i  smoothed_o, last_o
//   cfg      in   cfg_we_i (no wait)         cfg_wdata_i (image side)
//
// One transaction per cycle sustained while the output is not stalled; for the
// transaction that completes a neighborhood, the line buffer read and window
// sum fill S2, then the reciprocal divide fills the output register, where the
// result becomes valid.
// The output lags the input by one row plus one pixel; drain ticks flush it.
// rst_ni clears all control state; the line buffer holds no reset state.
// A stalled output back-pressures each stage in turn down to in_ready_o.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_edge_average #(
  parameter int unsigned MAX_SIZE = bfea_pkg::MAX_SIZE_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bfea_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        req_type_i,
  input  wire logic [bfea_pkg::PIX_W-1:0]  pixel_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [bfea_pkg::PIX_W-1:0]       smoothed_o,
  output logic                             last_o
);
  import bfea_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_SIZE);

  // Front: accept and position bookkeeping.
  logic             in_acc, in_take;
  logic [PIX_W-1:0] front_px;
  logic [AddrW-1:0] front_col;
  pos_info_t        front_info;

  // Window stage (S1).
  logic             s1_v_q, s1_go;
  logic [PIX_W-1:0] s1_px_q;
  logic [AddrW-1:0] s1_col_q;
  pos_info_t        s1_info_q;
  logic [PIX_W-1:0] lb_above, lb_two_above;
  logic [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0] win_cnt;

  // Sum stage (S2) and output register.
  logic             s2_v_q, s2_go, s2_ready, s2_last_q;
  logic [SUM_W-1:0] s2_sum_q;
  logic [CNT_W-1:0] s2_cnt_q;
  logic             out_v_q, out_adv, out_last_q;
  logic [PIX_W-1:0] out_pix_q;

  assign out_adv  = !out_v_q || out_ready_i;
  assign s2_go    = s2_v_q && out_adv;
  assign s2_ready = !s2_v_q || out_adv;
  // A non-emitting item only needs to update the window and line buffer.
  assign s1_go    = s1_v_q && (!s1_info_q.emit || s2_ready);

  assign in_ready_o = !s1_v_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  bfea_pos_ctrl #(
    .MAX_SIZE(MAX_SIZE)
  ) u_pos_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .acc_i      (in_acc),
    .req_type_i (req_type_i),
    .pixel_i    (pixel_i),
    .take_o     (in_take),
    .px_o       (front_px),
    .col_o      (front_col),
    .info_o     (front_info)
  );

  // Read the column at accept; write it back as the item leaves S1, so the
  // old row above shifts down to become the row two above.
  bfea_line_buf #(
    .MAX_SIZE(MAX_SIZE)
  ) u_line_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (in_take),
    .rd_addr_i     (front_col),
    .wr_en_i       (s1_go),
    .wr_addr_i     (s1_col_q),
    .wr_above_i    (s1_px_q),
    .wr_two_above_i(lb_above),
    .above_o       (lb_above),
    .two_above_o   (lb_two_above)
  );

  bfea_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (cfg_we_i),
    .shift_i(s1_go),
    .top_i  (lb_two_above),
    .mid_i  (lb_above),
    .px_i   (s1_px_q),
    .info_i (s1_info_q),
    .sum_o  (win_sum),
    .cnt_o  (win_cnt)
  );

  // Hold S1 payload while stalled.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_px_q   <= front_px;
      s1_col_q  <= front_col;
      s1_info_q <= front_info;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_info_q.emit) begin
      s2_sum_q  <= win_sum;
      s2_cnt_q  <= win_cnt;
      s2_last_q <= s1_info_q.last;
    end
    if (s2_go) begin
      out_pix_q  <= div_by_count(s2_sum_q, s2_cnt_q);
      out_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      // Advance S1.
      if (in_take) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      // Advance S2.
      if (s1_go && s1_info_q.emit) begin
        s2_v_q <= 1'b1;
      end else if (s2_go) begin
        s2_v_q <= 1'b0;
      end
      // Drop the output once taken unless a new result replaces it.
      if (s2_go) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign smoothed_o  = out_pix_q;
  assign last_o      = out_last_q;

  a_s2_cnt_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_cnt_q == CNT_INNER) || (s2_cnt_q == CNT_EDGE) ||
               (s2_cnt_q == CNT_CORNER) || (s2_cnt_q == CNT_SINGLE))
    else $error("neighbor count outside {1,4,6,9}");

  a_s2_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (32'(s2_sum_q) <= PIX_MAX * 32'(s2_cnt_q)))
    else $error("window sum exceeds count times full scale");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !out_adv) |=> (s2_v_q && $stable(s2_sum_q) && $stable(s2_cnt_q)))
    else $error("sum stage lost or changed a stalled result");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_v_q && s1_info_q.emit && s2_v_q && out_v_q))
    else $error("input stalled with free pipeline room");

endmodule

`default_nettype wire

>>> test/box_filter_3x3_edge_average_test.sv
// Self-checking testbench for the edge-averaged 3x3 box filter.
// Drives random and directed pixel streams, predicts each smoothed pixel in-line
// and checks the output channel. Depends on bfea_pkg and box_filter_3x3_edge_average.
`timescale 1ns / 1ps

module box_filter_3x3_edge_average_test;

  import bfea_pkg::*;

  // Request kinds on the input channel.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Pixel content styles for a frame.
  localparam int unsigned FILL_UNIFORM  = 0;
  localparam int unsigned FILL_EXTREME  = 1;
  localparam int unsigned FILL_CONSTANT = 2;

  localparam int unsigned LINE_DEPTH   = MAX_SIZE_DEF;
  localparam int unsigned SETTLE       = 16;        // covers the 3-stage pipe
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_PIX   = 560;
  localparam int unsigned PARTIAL_RUN  = 32;        // stays inside the first row

  typedef struct packed {
    logic             req;
    logic [PIX_W-1:0] pix;
  } stim_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic             is_last;
  } mean_rec_t;

  // DUT ports; every input starts at a known value.
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic             req_type_i  = REQ_PIXEL;
  logic [PIX_W-1:0] pixel_i     = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [PIX_W-1:0] smoothed_o;
  logic             last_o;

  // Pending transactions for the driver and smoothed pixels still owed by the DUT.
  stim_t     stim_q[$];
  mean_rec_t mean_fifo[$];

  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned pixels_sent = 0;
  int unsigned send_gap    = 0;
  int unsigned recv_stall  = 0;
  bit          send_calm   = 1'b0;
  bit          recv_calm   = 1'b0;

  // Shadow state of the filter: two line stores, the 3x3 window and positions.
  logic [PIX_W-1:0] prev_row  [LINE_DEPTH];
  logic [PIX_W-1:0] prev2_row [LINE_DEPTH];
  logic [PIX_W-1:0] win       [9];
  int unsigned      in_r, in_c, out_r, out_c;
  logic [CFG_W-1:0] side_reg;

  box_filter_3x3_edge_average u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .smoothed_o  (smoothed_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Effective side length: zero acts as one, oversize clamps to the line depth.
  function automatic int unsigned side_eff();
    if (side_reg == '0) return 1;
    if (side_reg > CFG_W'(LINE_DEPTH)) return LINE_DEPTH;
    return int'(side_reg);
  endfunction

  // Restart the frame: window and position counters back to zero.
  function automatic void clear_frame();
    foreach (win[i]) win[i] = '0;
    in_r  = 0;
    in_c  = 0;
    out_r = 0;
    out_c = 0;
  endfunction

  // Window row/column at offset k around base lies inside an s x s image.
  function automatic bit in_img(int unsigned base, int unsigned k, int unsigned s);
    if (base + k < 1) return 1'b0;
    return (base + k - 1) < s;
  endfunction

  // Advance the shadow filter by one accepted transaction and queue any result.
  task automatic box_mean_step(input logic req, input logic [PIX_W-1:0] pix);
    int unsigned      s;
    int unsigned      idx;
    int unsigned      sum;
    int unsigned      cnt;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    bit               live;
    mean_rec_t        res;
    s    = side_eff();
    live = in_r < s;
    // Drain ticks inside the image change nothing.
    if (live && req == REQ_DRAIN) return;
    // Past the image every transaction acts as a drain tick and feeds zeros.
    px  = live ? pix : '0;
    top = '0;
    mid = '0;
    if (in_c < LINE_DEPTH) begin
      top = prev2_row[in_c];
      mid = prev_row[in_c];
      prev2_row[in_c] = mid;
      prev_row[in_c]  = px;
    end
    for (int unsigned r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;

    idx = in_r * s + in_c;
    in_c++;
    if (in_c >= s) begin
      in_c = 0;
      in_r++;
    end
    // The first row plus one pixel only fill the window.
    if (idx < s + 1) return;

    sum = 0;
    cnt = 0;
    for (int unsigned r = 0; r < 3; r++) begin
      if (in_img(out_r, r, s)) begin
        for (int unsigned c = 0; c < 3; c++) begin
          if (in_img(out_c, c, s)) begin
            sum += win[r*3+c];
            cnt++;
          end
        end
      end
    end
    if (cnt == 0) cnt = 1;

    res.is_last = (out_r == s - 1) && (out_c == s - 1);
    res.mean    = PIX_W'(sum / cnt);
    mean_fifo.push_back(res);

    out_c++;
    if (out_c >= s) begin
      out_c = 0;
      out_r++;
    end
    // End of frame: all positions wrap, the next pixel starts a new image.
    if (res.is_last) begin
      in_r  = 0;
      in_c  = 0;
      out_r = 0;
      out_c = 0;
    end
  endtask

  // Idle length: mostly none or short, now and then long; none in calm stretches.
  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Driver: count the accepted transaction, then present the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    stim_t cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) box_mean_step(req_type_i, pixel_i);
      if ($urandom_range(0, 149) == 0) send_calm <= !send_calm;
      // Hold valid and payload until accepted.
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (stim_q.size() != 0) begin
          cur = stim_q.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= cur.req;
          pixel_i    <= cur.pix;
          send_gap   <= idle_len(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    mean_rec_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (mean_fifo.size() == 0) begin
          $display("%0t: result with none expected: smoothed=%0d last=%0b",
                   $time, smoothed_o, last_o);
          errors++;
        end else begin
          want = mean_fifo.pop_front();
          if (smoothed_o !== want.mean) begin
            $display("%0t: smoothed mismatch: expected %0d, actual %0d",
                     $time, want.mean, smoothed_o);
            errors++;
          end
          if (last_o !== want.is_last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.is_last, last_o);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 149) == 0) recv_calm <= !recv_calm;
      // Stall the output for a random stretch after each ready cycle.
      if (recv_stall != 0) begin
        out_ready_i <= 1'b0;
        recv_stall  <= recv_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall  <= idle_len(recv_calm);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_item(input logic req, input logic [PIX_W-1:0] pix);
    stim_t it;
    it.req = req;
    it.pix = pix;
    stim_q.push_back(it);
    if (req == REQ_PIXEL) pixels_sent++;
  endtask

  // Block until every queued transaction is accepted and every result is back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid_i || mean_fifo.size() != 0);
  endtask

  // Write the side register once the pipe is empty; the write restarts the frame.
  task automatic write_size(input logic [CFG_W-1:0] v);
    wait_idle();
    repeat (SETTLE) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    side_reg = v;
    clear_frame();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(int unsigned fill, logic [PIX_W-1:0] konst);
    if (fill == FILL_EXTREME) return $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
    if (fill == FILL_CONSTANT) return konst;
    return PIX_W'($urandom_range(0, PIX_MAX));
  endfunction

  // One whole frame at the current side: pixels with stray drain ticks, then a
  // flush of side+1 transactions mixing drain ticks and pixels past the image.
  // A pause index below s*s holds the sender until all results are back.
  task automatic send_frame(input int unsigned fill, input int pause_at);
    int unsigned      s;
    logic [PIX_W-1:0] konst;
    s     = side_eff();
    konst = PIX_W'($urandom_range(0, PIX_MAX));
    for (int i = 0; i < int'(s * s); i++) begin
      if ($urandom_range(0, 9) == 0) push_item(REQ_DRAIN, PIX_W'($urandom));
      if (i == pause_at) wait_idle();
      push_item(REQ_PIXEL, pick_pixel(fill, konst));
    end
    for (int unsigned i = 0; i <= s; i++) begin
      if ($urandom_range(0, 1) != 0) push_item(REQ_DRAIN, PIX_W'($urandom));
      else push_item(REQ_PIXEL, PIX_W'($urandom));
    end
    // Drain ticks after the frame find the filter idle and are dropped.
    if ($urandom_range(0, 3) == 0) push_item(REQ_DRAIN, PIX_W'($urandom));
  endtask

  function automatic logic [CFG_W-1:0] random_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 82) return CFG_W'($urandom_range(1, 8));
    if (r < 94) return CFG_W'($urandom_range(9, 20));
    return '0;
  endfunction

  initial begin : stimulus
    int unsigned pix_base;
    int unsigned pick;
    int unsigned n;
    bit          paused_once;
    foreach (prev_row[i]) begin
      prev_row[i]  = '0;
      prev2_row[i] = '0;
    end
    side_reg = CFG_W'(SIZE_RESET);
    clear_frame();
    paused_once = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset side of 1024: drain ticks while idle, then a short run of the
    // first row, which owes no result yet. The next write cuts the frame.
    push_item(REQ_DRAIN, 8'hA5);
    push_item(REQ_DRAIN, 8'h5A);
    for (int unsigned i = 0; i < PARTIAL_RUN; i++) begin
      push_item(REQ_PIXEL, PIX_W'($urandom_range(0, PIX_MAX)));
    end

    // Zero acts as one: single-pixel image, flushed by a drain and a pixel.
    write_size('0);
    push_item(REQ_DRAIN, '0);
    push_item(REQ_PIXEL, PIX_W'(PIX_MAX));
    push_item(REQ_DRAIN, '0);
    push_item(REQ_PIXEL, 8'h3C);

    // 2x2: every output is a corner, divisor four.
    write_size(CFG_W'(2));
    push_item(REQ_PIXEL, '0);
    push_item(REQ_PIXEL, PIX_W'(PIX_MAX));
    push_item(REQ_PIXEL, PIX_W'(PIX_MAX));
    push_item(REQ_PIXEL, '0);
    push_item(REQ_DRAIN, '0);
    push_item(REQ_DRAIN, PIX_W'(PIX_MAX));
    push_item(REQ_PIXEL, 8'h77);

    // 3x3 all full scale: the centre hits the largest sum; a drain tick
    // mid-image is dropped; the flush uses pixels past the image.
    write_size(CFG_W'(3));
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push_item(REQ_DRAIN, PIX_W'(PIX_MAX));
      push_item(REQ_PIXEL, PIX_W'(PIX_MAX));
    end
    push_item(REQ_PIXEL, '0);
    push_item(REQ_DRAIN, '0);
    push_item(REQ_PIXEL, PIX_W'(PIX_MAX));
    push_item(REQ_DRAIN, PIX_W'(PIX_MAX));

    // Random part: mostly whole frames, some size changes and cut frames.
    pix_base = pixels_sent;
    while (pixels_sent - pix_base < RANDOM_PIX) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        write_size(random_size());
      end else if (pick < 27) begin
        // Cut a frame short, then restart it with a write.
        n = $urandom_range(0, side_eff() * side_eff() + side_eff());
        for (int unsigned i = 0; i < n; i++) begin
          if ($urandom_range(0, 7) == 0) push_item(REQ_DRAIN, PIX_W'($urandom));
          else push_item(REQ_PIXEL, PIX_W'($urandom));
        end
        write_size($urandom_range(0, 1) ? side_reg : random_size());
      end else begin
        if (!paused_once) begin
          send_frame(FILL_UNIFORM, int'(side_eff() * side_eff() / 2));
          paused_once = 1'b1;
        end else begin
          send_frame($urandom_range(0, 9) < 7 ? FILL_UNIFORM :
                     ($urandom_range(0, 1) ? FILL_EXTREME : FILL_CONSTANT),
                     $urandom_range(0, 19) == 0 ?
                       int'($urandom_range(0, side_eff() * side_eff() - 1)) : -1);
        end
      end
    end

    // Oversize write clamps to 1024: a short partial frame inside the first row.
    write_size(CFG_W'(2047));
    for (int unsigned i = 0; i < PARTIAL_RUN; i++) begin
      push_item(REQ_PIXEL, pick_pixel(FILL_EXTREME, '0));
    end

    // Let the pipe empty, then keep watching for stray results.
    wait_idle();
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0 && mean_fifo.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bfea_pkg.sv
hw/rtl/bfea_pos_ctrl.sv
hw/rtl/bfea_line_buf.sv
hw/rtl/bfea_window.sv
hw/rtl/box_filter_3x3_edge_average.sv
test/box_filter_3x3_edge_average_test.sv
